>>> rtl/core/ffp_pkg.sv
// Shared types and constants for the FASTA/FASTQ record parser.
// No dependencies; imported by every module of the block.
package ffp_pkg;

	localparam logic [7:0] CH_FASTA = 8'h3E;	// '>'
	localparam logic [7:0] CH_FASTQ = 8'h40;	// '@'
	localparam logic [7:0] CH_PLUS  = 8'h2B;	// '+'
	localparam logic [7:0] CH_NL    = 8'h0A;	// '\n'

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		KIND_HDR   = 3'd0,
		KIND_SEQ   = 3'd1,
		KIND_QUAL  = 3'd2,
		KIND_DONE  = 3'd3,
		KIND_ABORT = 3'd4,
		KIND_ERROR = 3'd5
	} kind_t;

	typedef enum logic [9:0] {
		MODE_FIRST   = 10'b00_0000_0001,
		MODE_FA_HDR  = 10'b00_0000_0010,
		MODE_FA_SEQ  = 10'b00_0000_0100,
		MODE_FQ_HDR  = 10'b00_0000_1000,
		MODE_FQ_SEQ  = 10'b00_0001_0000,
		MODE_FQ_PLUS = 10'b00_0010_0000,
		MODE_FQ_QUAL = 10'b00_0100_0000,
		MODE_NEXT    = 10'b00_1000_0000,
		MODE_ENDED   = 10'b01_0000_0000,
		MODE_HALTED  = 10'b10_0000_0000
	} mode_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
	} result_t;

	// queue flags seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

>>> rtl/core/fasta_fastq_record_parser_top.sv
// FASTA/FASTQ record parser top level: front end, result queue, output stage.
// Throughput: one input beat per cycle, sustained while the out side takes beats.
// A result is written into the result queue when its input beat is taken, then moves
// into the output register once that register is free (it holds while out_ready is low).
// Input ready follows the two-entry queue not being full.
// Reset (arst_n low): parser expects the first header, queue and output are emptied.
module fasta_fastq_record_parser_top
	import ffp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] kind
);

	queue_status_t q_status;
	logic          push, pop;
	result_t       push_data, pop_data;

	ffp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.q_status      (q_status),
		.push          (push),
		.push_data     (push_data)
	);

	ffp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	ffp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.kind      (kind)
	);

endmodule

>>> rtl/core/ffp_front.sv
// Front end: accepts input beats and runs the line/record state machine.
// Depends on ffp_pkg; pushes classified results into ffp_queue.
module ffp_front
	import ffp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          end_of_stream,
	input  queue_status_t q_status,
	output logic          push,
	output result_t       push_data
);

	mode_t   mode_q, mode_d;
	logic    ls_q, ls_d;
	logic    lahb_q, lahb_d;
	logic    res_valid;
	result_t res;
	logic    is_nl;
	logic    accept;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign is_nl    = (data_byte == CH_NL);

	always_comb begin
		mode_d       = mode_q;
		ls_d         = ls_q;
		lahb_d       = lahb_q;
		res_valid    = 1'b0;
		res.out_byte = 8'h00;
		res.kind     = KIND_HDR;
		if (end_of_stream) begin
			unique case (mode_q)
				MODE_FIRST: begin
					mode_d = MODE_HALTED; res_valid = 1'b1; res.kind = KIND_ERROR;
				end
				MODE_FA_HDR, MODE_FQ_HDR: begin
					mode_d = MODE_ENDED; res_valid = 1'b1; res.kind = KIND_ABORT;
				end
				MODE_FA_SEQ: begin
					mode_d    = MODE_ENDED;
					res_valid = 1'b1;
					res.kind  = (lahb_q || !ls_q) ? KIND_DONE : KIND_ABORT;
				end
				MODE_FQ_SEQ: begin
					res_valid = 1'b1;
					if (lahb_q || !ls_q) begin
						mode_d = MODE_HALTED; res.kind = KIND_ERROR;
					end else begin
						mode_d = MODE_ENDED; res.kind = KIND_ABORT;
					end
				end
				MODE_FQ_PLUS: begin
					mode_d = MODE_HALTED; res_valid = 1'b1; res.kind = KIND_ERROR;
				end
				MODE_FQ_QUAL: begin
					res_valid = 1'b1;
					if (ls_q) begin
						mode_d = MODE_HALTED; res.kind = KIND_ERROR;
					end else begin
						mode_d = MODE_ENDED; res.kind = KIND_DONE;
					end
				end
				MODE_NEXT: mode_d = MODE_ENDED;
				default: ;	// ended or halted: sticky until reset
			endcase
		end else begin
			unique case (mode_q)
				MODE_FIRST, MODE_NEXT: begin
					ls_d = is_nl;
					if (data_byte == CH_FASTA) mode_d = MODE_FA_HDR;
					else if (data_byte == CH_FASTQ) mode_d = MODE_FQ_HDR;
					else begin
						mode_d = MODE_HALTED; res_valid = 1'b1; res.kind = KIND_ERROR;
					end
				end
				MODE_FA_HDR, MODE_FQ_HDR: begin
					ls_d = is_nl;
					if (is_nl) begin
						mode_d = (mode_q == MODE_FA_HDR) ? MODE_FA_SEQ : MODE_FQ_SEQ;
						lahb_d = 1'b0;
					end else begin
						res_valid = 1'b1; res.out_byte = data_byte; res.kind = KIND_HDR;
					end
				end
				MODE_FA_SEQ: begin
					ls_d = is_nl;
					if (ls_q && data_byte == CH_FASTA) begin
						mode_d = MODE_FA_HDR; res_valid = 1'b1; res.kind = KIND_DONE;
					end else begin
						if (ls_q) lahb_d = 1'b1;
						if (!is_nl) begin
							res_valid = 1'b1; res.out_byte = data_byte; res.kind = KIND_SEQ;
						end
					end
				end
				MODE_FQ_SEQ: begin
					ls_d = is_nl;
					if (ls_q) lahb_d = 1'b1;
					if (ls_q && data_byte == CH_PLUS) mode_d = MODE_FQ_PLUS;
					else if (!is_nl) begin
						res_valid = 1'b1; res.out_byte = data_byte; res.kind = KIND_SEQ;
					end
				end
				MODE_FQ_PLUS: begin
					// '+' line content is dropped
					ls_d = is_nl;
					if (is_nl) mode_d = MODE_FQ_QUAL;
				end
				MODE_FQ_QUAL: begin
					ls_d      = is_nl;
					res_valid = 1'b1;
					if (is_nl) begin
						mode_d = MODE_NEXT; res.kind = KIND_DONE;
					end else begin
						res.out_byte = data_byte; res.kind = KIND_QUAL;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIRST;
			ls_q   <= 1'b1;
			lahb_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			ls_q   <= ls_d;
			lahb_q <= lahb_d;
		end
	end

	assign push      = accept && res_valid;
	assign push_data = res;

endmodule

>>> rtl/core/ffp_queue.sv
// Two-entry result queue between the parser front end and the output stage.
// Depends on ffp_pkg.
module ffp_queue
	import ffp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  result_t       push_data,
	input  logic          pop,
	output result_t       pop_data,
	output queue_status_t status
);

	localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	result_t         mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign status.full  = (count_q == CntW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			priority if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push)     count_q <= count_q - 1'b1;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(status.empty || status.full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/ffp_back.sv
// Back end: output register that drains the result queue onto the out channel.
// Depends on ffp_pkg.
module ffp_back
	import ffp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t q_status,
	input  result_t       q_data,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic [2:0]    kind
);

	logic    valid_q;
	result_t data_q;

	assign pop = !q_status.empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) data_q <= q_data;
	end

	assign out_valid = valid_q;
	assign out_byte  = data_q.out_byte;
	assign kind      = data_q.kind;

endmodule
